// ===== rtl/rybsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rybsd_pkg: shared types and constants for the ray/yawed-box distance block
// Formats, field widths, pipeline latencies and payload structs.
// ----------------------------------------------------------------------------
package rybsd_pkg;

	// Fixed-point formats.
	localparam int FRAC_BITS  = 16;
	localparam int TRIG_SHIFT = 16;
	localparam int POS_W      = 32;
	localparam int TRIG_W     = 18;
	localparam int HALF_W     = 31;
	localparam int DIST_W     = 31;

	// Internal widths.
	localparam int DIF_W  = POS_W + 1;
	localparam int PO_W   = TRIG_W + DIF_W;
	localparam int PV_W   = TRIG_W + POS_W;
	localparam int O_W    = PO_W + 1;
	localparam int R_W    = PV_W + 1;
	localparam int H_W    = HALF_W + TRIG_SHIFT;
	localparam int NUM_W  = O_W + 1;
	localparam int LEN_W  = 32;
	localparam int SUM_W  = 2 * LEN_W;
	localparam int SQR_W  = LEN_W + 2;
	localparam int HI_W   = NUM_W - 32;
	localparam int PH_W   = HI_W + LEN_W;
	localparam int PROD_W = PH_W + 32;
	localparam int Q_W    = 33;
	localparam int B_W    = Q_W + 1;

	// Pipeline latencies.
	localparam int SQ_LAT   = LEN_W;
	localparam int DIV_LAT  = Q_W + 4;
	localparam int PIPE_LAT = 4 + SQ_LAT + DIV_LAT + 1;

	// Bound magnitude clamp and largest reportable distance.
	localparam logic [Q_W-1:0] MAG_SAT = Q_W'(1) << (Q_W - 1);
	localparam logic signed [B_W-1:0] DIST_MAX = B_W'((64'd1 << DIST_W) - 64'd1);

	localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) << TRIG_SHIFT;
	localparam logic [HALF_W-1:0] HALF_ONE = HALF_W'(1) << FRAC_BITS;

	localparam int IDX_W = 4;

	// Register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_CENTER_X = 4'd0,
		REG_CENTER_Y = 4'd1,
		REG_CENTER_Z = 4'd2,
		REG_COS_YAW  = 4'd3,
		REG_SIN_YAW  = 4'd4,
		REG_HALF_X   = 4'd5,
		REG_HALF_Y   = 4'd6,
		REG_HALF_Z   = 4'd7
	} reg_idx_t;

	// Input ray.
	typedef struct packed {
		logic signed [POS_W-1:0] origin_x;
		logic signed [POS_W-1:0] origin_y;
		logic signed [POS_W-1:0] origin_z;
		logic signed [POS_W-1:0] dir_x;
		logic signed [POS_W-1:0] dir_y;
		logic signed [POS_W-1:0] dir_z;
	} ray_in_t;

	// Result.
	typedef struct packed {
		logic              hit;
		logic [DIST_W-1:0] distance;
	} ray_out_t;

endpackage

// ===== rtl/rybsd_isqrt.sv =====
// ----------------------------------------------------------------------------
// rybsd_isqrt: pipelined integer square root
// One root bit per stage; root holds the floor square root of x from the last stage.
// ----------------------------------------------------------------------------
module rybsd_isqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [rybsd_pkg::SUM_W-1:0] x,
	output logic [rybsd_pkg::LEN_W-1:0] root
);
	import rybsd_pkg::*;

	logic [SQR_W-1:0] rem_s  [1:LEN_W];
	logic [LEN_W-1:0] root_s [1:LEN_W];
	logic [SUM_W-1:0] xs_s   [1:LEN_W];

	for (genvar k = 1; k <= LEN_W; k++) begin : g_step
		logic [SQR_W-1:0] rem_in;
		logic [LEN_W-1:0] root_in;
		logic [SUM_W-1:0] xs_in;
		logic [SQR_W+1:0] cur;
		logic [SQR_W+1:0] trial;
		logic             ge;

		// Stage inputs come from the operand or the previous stage.
		if (k == 1) begin : g_first
			always_comb begin
				rem_in  = '0;
				root_in = '0;
				xs_in   = x;
			end
		end else begin : g_next
			always_comb begin
				rem_in  = rem_s[k-1];
				root_in = root_s[k-1];
				xs_in   = xs_s[k-1];
			end
		end

		// Bring down two bits and try the next root bit.
		always_comb begin
			cur   = {rem_in, xs_in[SUM_W-1 -: 2]};
			trial = {{(SQR_W - LEN_W){1'b0}}, root_in, 2'b01};
			ge    = cur >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? SQR_W'(cur - trial) : SQR_W'(cur);
				root_s[k] <= {root_in[LEN_W-2:0], ge};
				xs_s[k]   <= {xs_in[SUM_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[LEN_W];

endmodule

// ===== rtl/rybsd_div.sv =====
// ----------------------------------------------------------------------------
// rybsd_div: pipelined slab bound num * len / den
// Truncates toward zero and clamps the magnitude to MAG_SAT.
// ----------------------------------------------------------------------------
module rybsd_div (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [rybsd_pkg::NUM_W-1:0] num,
	input  logic signed [rybsd_pkg::R_W-1:0]   den,
	input  logic        [rybsd_pkg::LEN_W-1:0] len,
	output logic signed [rybsd_pkg::B_W-1:0]   bound
);
	import rybsd_pkg::*;

	logic [NUM_W-1:0]  a_abs;
	logic [R_W-1:0]    d_abs;
	logic [63:0]       pl_s1;
	logic [PH_W-1:0]   ph_s1;
	logic [R_W-1:0]    d_s1;
	logic              neg_s1;
	logic [PROD_W-1:0] n_s2;
	logic [R_W-1:0]    d_s2;
	logic              neg_s2;
	logic [PROD_W-Q_W-1:0] n_hi;

	logic [R_W-1:0] rem_s [0:Q_W];
	logic [Q_W-1:0] low_s [0:Q_W];
	logic [Q_W-1:0] q_s   [0:Q_W];
	logic [R_W-1:0] d_s   [0:Q_W];
	logic           ovf_s [0:Q_W];
	logic           neg_s [0:Q_W];

	logic [Q_W-1:0] mag;

	// Magnitudes of the operands.
	always_comb begin
		a_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		d_abs = den[R_W-1] ? R_W'(-den) : R_W'(den);
	end

	// Partial products of |num| * len, then their sum.
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1  <= 64'(a_abs[31:0]) * 64'(len);
			ph_s1  <= PH_W'(a_abs[NUM_W-1:32]) * PH_W'(len);
			d_s1   <= d_abs;
			neg_s1 <= num[NUM_W-1] ^ den[R_W-1];
			n_s2   <= {ph_s1, 32'b0} + PROD_W'(pl_s1);
			d_s2   <= d_s1;
			neg_s2 <= neg_s1;
		end
	end

	// A quotient too wide for Q_W bits is flagged and clamped later.
	assign n_hi = n_s2[PROD_W-1:Q_W];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= n_hi[R_W-1:0];
			low_s[0] <= n_s2[Q_W-1:0];
			q_s[0]   <= '0;
			d_s[0]   <= d_s2;
			ovf_s[0] <= n_hi >= (PROD_W-Q_W)'(d_s2);
			neg_s[0] <= neg_s2;
		end
	end

	// Restoring division, one quotient bit per stage.
	for (genvar k = 1; k <= Q_W; k++) begin : g_bit
		logic [R_W:0] cur;
		logic         ge;

		always_comb begin
			cur = {rem_s[k-1], low_s[k-1][Q_W-1]};
			ge  = cur >= {1'b0, d_s[k-1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? R_W'(cur - {1'b0, d_s[k-1]}) : R_W'(cur);
				low_s[k] <= {low_s[k-1][Q_W-2:0], 1'b0};
				q_s[k]   <= {q_s[k-1][Q_W-2:0], ge};
				d_s[k]   <= d_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	// Clamp and apply the sign.
	assign mag = (ovf_s[Q_W] || q_s[Q_W] > MAG_SAT) ? MAG_SAT : q_s[Q_W];

	always_ff @(posedge clk) begin
		if (en) begin
			bound <= neg_s[Q_W] ? -B_W'(mag) : B_W'(mag);
		end
	end

endmodule

// ===== rtl/ray_yaw_box_slab_distance_top.sv =====
// ----------------------------------------------------------------------------
// ray_yaw_box_slab_distance_top: ray against yaw-rotated box, slab method
// Gives a hit flag and the entry distance along the normalized direction.
// ----------------------------------------------------------------------------
// Usage: the block takes one ray per clock cycle while ray_stall is low, and
// returns one result per ray, in order. After the front stages, the pipeline
// runs through the 32-stage square root that forms the direction length,
// then six parallel divider pipelines that spend one stage per quotient bit,
// then a final compare stage and a two-entry output buffer. Box registers
// may be written only while no ray is in flight.
module ray_yaw_box_slab_distance_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            ray_valid,
	output logic                            ray_stall,
	input  rybsd_pkg::ray_in_t              ray,
	output logic                            res_valid,
	input  logic                            res_stall,
	output rybsd_pkg::ray_out_t             res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rybsd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [rybsd_pkg::POS_W-1:0]     cfg_data
);
	import rybsd_pkg::*;

	typedef struct packed {
		logic [2:0][NUM_W-1:0] num_lo;
		logic [2:0][NUM_W-1:0] num_hi;
		logic [2:0][R_W-1:0]   den;
		logic [2:0]            skip;
		logic                  early_miss;
	} ctx_t;

	typedef struct packed {
		logic [2:0] skip;
		logic       early_miss;
	} flag_t;

	// Box registers.
	logic signed [POS_W-1:0]  center_x_q, center_y_q, center_z_q;
	logic signed [TRIG_W-1:0] cos_q, sin_q;
	logic [HALF_W-1:0]        half_x_q, half_y_q, half_z_q;

	logic en;
	logic vld_s [1:PIPE_LAT];

	logic signed [DIF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [POS_W-1:0] vx_s1, vy_s1, vz_s1;
	logic [SUM_W-1:0]        sqx_s1, sqy_s1, sqz_s1;
	logic                    vzero_s1;
	logic [POS_W-1:0]        ax, ay, az;

	logic signed [PO_W-1:0]  pcdx_s2, psdz_s2, psdx_s2, pcdz_s2;
	logic signed [PV_W-1:0]  pcvx_s2, psvz_s2, psvx_s2, pcvz_s2;
	logic signed [DIF_W-1:0] dy_s2;
	logic signed [POS_W-1:0] vy_s2;
	logic [SUM_W-1:0]        sum_s2;
	logic                    vzero_s2;

	logic signed [O_W-1:0] o_s3 [3];
	logic signed [R_W-1:0] r_s3 [3];
	logic [SUM_W-1:0]      sum_s3;
	logic                  vzero_s3;

	logic [H_W-1:0]          h [3];
	logic [O_W-1:0]          oabs [3];
	logic [2:0]              oout;
	logic signed [NUM_W-1:0] hs [3];
	ctx_t                    ctx_d;
	ctx_t                    ctx_s4;
	logic [SUM_W-1:0]        sum_s4;

	ctx_t             ctx_dly_s [1:SQ_LAT];
	logic [LEN_W-1:0] len;
	ctx_t             ctx_sq;
	flag_t            flg_dly_s [1:DIV_LAT];

	logic signed [B_W-1:0] b_lo [3];
	logic signed [B_W-1:0] b_hi [3];
	logic signed [B_W-1:0] t0_sf [3];
	logic signed [B_W-1:0] t1_sf [3];
	logic                  miss_sf;

	logic signed [B_W-1:0] near_t, far_t;
	ray_out_t              res_d;

	ray_out_t   fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	// Configuration writes; every write completes at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			cos_q      <= TRIG_ONE;
			sin_q      <= '0;
			half_x_q   <= HALF_ONE;
			half_y_q   <= HALF_ONE;
			half_z_q   <= HALF_ONE;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_CENTER_Z: center_z_q <= cfg_data;
				REG_COS_YAW:  cos_q      <= cfg_data[TRIG_W-1:0];
				REG_SIN_YAW:  sin_q      <= cfg_data[TRIG_W-1:0];
				REG_HALF_X:   half_x_q   <= cfg_data[HALF_W-1:0];
				REG_HALF_Y:   half_y_q   <= cfg_data[HALF_W-1:0];
				REG_HALF_Z:   half_z_q   <= cfg_data[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves while the output buffer has room.
	assign en        = cnt_q != 2'd2;
	assign ray_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= PIPE_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= ray_valid;
			for (int i = 2; i <= PIPE_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Stage 1: offsets from the box centre and squared direction terms.
	always_comb begin
		ax = ray.dir_x[POS_W-1] ? POS_W'(-ray.dir_x) : POS_W'(ray.dir_x);
		ay = ray.dir_y[POS_W-1] ? POS_W'(-ray.dir_y) : POS_W'(ray.dir_y);
		az = ray.dir_z[POS_W-1] ? POS_W'(-ray.dir_z) : POS_W'(ray.dir_z);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= DIF_W'(ray.origin_x) - DIF_W'(center_x_q);
			dy_s1    <= DIF_W'(ray.origin_y) - DIF_W'(center_y_q);
			dz_s1    <= DIF_W'(ray.origin_z) - DIF_W'(center_z_q);
			vx_s1    <= ray.dir_x;
			vy_s1    <= ray.dir_y;
			vz_s1    <= ray.dir_z;
			sqx_s1   <= SUM_W'(ax) * SUM_W'(ax);
			sqy_s1   <= SUM_W'(ay) * SUM_W'(ay);
			sqz_s1   <= SUM_W'(az) * SUM_W'(az);
			vzero_s1 <= (ray.dir_x == '0) && (ray.dir_y == '0) && (ray.dir_z == '0);
		end
	end

	// Stage 2: rotation products and the squared length.
	always_ff @(posedge clk) begin
		if (en) begin
			pcdx_s2  <= cos_q * dx_s1;
			psdz_s2  <= sin_q * dz_s1;
			psdx_s2  <= sin_q * dx_s1;
			pcdz_s2  <= cos_q * dz_s1;
			pcvx_s2  <= cos_q * vx_s1;
			psvz_s2  <= sin_q * vz_s1;
			psvx_s2  <= sin_q * vx_s1;
			pcvz_s2  <= cos_q * vz_s1;
			dy_s2    <= dy_s1;
			vy_s2    <= vy_s1;
			sum_s2   <= sqx_s1 + sqy_s1 + sqz_s1;
			vzero_s2 <= vzero_s1;
		end
	end

	// Stage 3: origin and direction in the box frame.
	always_ff @(posedge clk) begin
		if (en) begin
			o_s3[0]  <= O_W'(pcdx_s2) - O_W'(psdz_s2);
			o_s3[1]  <= O_W'(dy_s2) <<< TRIG_SHIFT;
			o_s3[2]  <= O_W'(psdx_s2) + O_W'(pcdz_s2);
			r_s3[0]  <= R_W'(pcvx_s2) - R_W'(psvz_s2);
			r_s3[1]  <= R_W'(vy_s2) <<< TRIG_SHIFT;
			r_s3[2]  <= R_W'(psvx_s2) + R_W'(pcvz_s2);
			sum_s3   <= sum_s2;
			vzero_s3 <= vzero_s2;
		end
	end

	// Stage 4: slab numerators and the early miss cases.
	always_comb begin
		h[0] = {half_x_q, {TRIG_SHIFT{1'b0}}};
		h[1] = {half_y_q, {TRIG_SHIFT{1'b0}}};
		h[2] = {half_z_q, {TRIG_SHIFT{1'b0}}};
		for (int a = 0; a < 3; a++) begin
			oabs[a] = o_s3[a][O_W-1] ? O_W'(-o_s3[a]) : O_W'(o_s3[a]);
			oout[a] = oabs[a] > O_W'(h[a]);
			hs[a]   = NUM_W'(h[a]);
			ctx_d.num_lo[a] = -hs[a] - NUM_W'(o_s3[a]);
			ctx_d.num_hi[a] = hs[a] - NUM_W'(o_s3[a]);
			ctx_d.den[a]    = r_s3[a];
			ctx_d.skip[a]   = r_s3[a] == '0;
		end
		ctx_d.early_miss = vzero_s3 || (oout == 3'b000) || ((ctx_d.skip & oout) != 3'b000);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= ctx_d;
			sum_s4 <= sum_s3;
		end
	end

	// Direction length, with the ray context kept in step alongside.
	rybsd_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.x    (sum_s4),
		.root (len)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_dly_s[1] <= ctx_s4;
			for (int i = 2; i <= SQ_LAT; i++) begin
				ctx_dly_s[i] <= ctx_dly_s[i-1];
			end
		end
	end

	assign ctx_sq = ctx_dly_s[SQ_LAT];

	// Both slab bounds of every axis.
	for (genvar a = 0; a < 3; a++) begin : g_axis
		rybsd_div u_div_lo (
			.clk   (clk),
			.en    (en),
			.num   ($signed(ctx_sq.num_lo[a])),
			.den   ($signed(ctx_sq.den[a])),
			.len   (len),
			.bound (b_lo[a])
		);

		rybsd_div u_div_hi (
			.clk   (clk),
			.en    (en),
			.num   ($signed(ctx_sq.num_hi[a])),
			.den   ($signed(ctx_sq.den[a])),
			.len   (len),
			.bound (b_hi[a])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_dly_s[1] <= '{skip: ctx_sq.skip, early_miss: ctx_sq.early_miss};
			for (int i = 2; i <= DIV_LAT; i++) begin
				flg_dly_s[i] <= flg_dly_s[i-1];
			end
		end
	end

	// Final stage: order each axis pair; a skipped axis leaves the interval open.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				if (flg_dly_s[DIV_LAT].skip[a]) begin
					t0_sf[a] <= '0;
					t1_sf[a] <= B_W'(MAG_SAT);
				end else if (b_lo[a] > b_hi[a]) begin
					t0_sf[a] <= b_hi[a];
					t1_sf[a] <= b_lo[a];
				end else begin
					t0_sf[a] <= b_lo[a];
					t1_sf[a] <= b_hi[a];
				end
			end
			miss_sf <= flg_dly_s[DIV_LAT].early_miss;
		end
	end

	// Entry and exit over all slabs, then the hit decision.
	always_comb begin
		near_t = '0;
		far_t  = B_W'(MAG_SAT);
		for (int a = 0; a < 3; a++) begin
			if (t0_sf[a] > near_t) begin
				near_t = t0_sf[a];
			end
			if (t1_sf[a] < far_t) begin
				far_t = t1_sf[a];
			end
		end
		res_d.hit      = !miss_sf && (near_t <= far_t) && (near_t <= DIST_MAX);
		res_d.distance = res_d.hit ? near_t[DIST_W-1:0] : '0;
	end

	// Two-entry output buffer.
	assign push      = en && vld_s[PIPE_LAT];
	assign pop       = res_valid && !res_stall;
	assign res_valid = cnt_q != 2'd0;
	assign res       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
